[hdl/direct_mapped_result_cache_unit_assert.svh]
// Assertion macros used by the result cache RTL modules.
`ifndef DIRECT_MAPPED_RESULT_CACHE_UNIT_ASSERT_SVH
`define DIRECT_MAPPED_RESULT_CACHE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMRC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DMRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dmrc_pkg.sv]
// Shared types, constants and helpers of the direct-mapped result cache.
`default_nettype none

package dmrc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;
    localparam int CNT_W  = 32;
    localparam int CFG_W  = 13;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 13'd4096;

    // Remainder bits resolved per divide step, and the steps for one key
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = KEY_W / MOD_BITS;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } item_t;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIVIDE,
        FRONT_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BACK_CLEAR,
        BACK_IDLE,
        BACK_EXEC
    } back_state_t;

    // Restoring remainder over MOD_BITS dividend bits, most significant first.
    // Expects rem < divisor and returns a value that keeps that bound.
    function automatic logic [CFG_W-1:0] mod_step(
        input logic [CFG_W-1:0]    rem,
        input logic [MOD_BITS-1:0] bits,
        input logic [CFG_W-1:0]    divisor
    );
        logic [CFG_W:0]   t;
        logic [CFG_W-1:0] r;
        r = rem;
        for (int i = MOD_BITS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, divisor}) begin
                t = t - {1'b0, divisor};
            end
            r = t[CFG_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/dmrc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/dmrc_queue.sv]
// Short first-in first-out queue between the front and back halves.
`default_nettype none

module dmrc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] head_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             push_ok;
    logic             pop_ok;

    assign full      = (count_reg == (PTR_W + 1)'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_ok   = push && !full;
    assign pop_ok    = pop && !empty;
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_ok) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PTR_W + 1)'(push_ok) - (PTR_W + 1)'(pop_ok);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hdl/dmrc_front.sv]
// Front half: accepts items and works out each key's slot with an iterative modulo.
`default_nettype none

`include "direct_mapped_result_cache_unit_assert.svh"

module dmrc_front #(
    parameter int DEPTH = 4096
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           init_done,
    input  wire logic [dmrc_pkg::CFG_W-1:0]     table_size,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [dmrc_pkg::KEY_W-1:0]     s_key,
    input  wire logic [dmrc_pkg::DATA_W-1:0]    s_entry_data,
    input  wire logic                           q_full,
    output logic                                q_push,
    output dmrc_pkg::item_t                     q_item,
    output logic      [$clog2(DEPTH)-1:0]       q_slot
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CFG_W   = dmrc_pkg::CFG_W;
    localparam int KEY_W   = dmrc_pkg::KEY_W;
    localparam int N_LIMIT = (DEPTH > (2 ** CFG_W) - 1) ? (2 ** CFG_W) - 1 : DEPTH;
    localparam logic [CFG_W-1:0] N_MAX = CFG_W'(N_LIMIT);

    dmrc_pkg::front_state_t state_reg, state_next;
    dmrc_pkg::item_t        item_reg, item_next;
    logic [KEY_W-1:0]           div_reg, div_next;
    logic [CFG_W-1:0]           rem_reg, rem_next;
    logic [CFG_W-1:0]           n_reg, n_next;
    logic [dmrc_pkg::STEP_W-1:0] step_reg, step_next;
    logic [CFG_W-1:0]           n_in;

    // Zero counts as one slot; clamp anything above the table depth
    assign n_in = (table_size == '0) ? CFG_W'(1) :
                  ((table_size > N_MAX) ? N_MAX : table_size);

    assign q_item = item_reg;
    assign q_slot = ADDR_W'(rem_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dmrc_pkg::FRONT_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        n_reg    <= n_next;
    end

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        q_push     = 1'b0;
        unique case (state_reg)
            dmrc_pkg::FRONT_IDLE: begin
                s_ready = init_done;
                if (s_valid && init_done) begin
                    item_next.cmd  = dmrc_pkg::cmd_t'(s_cmd);
                    item_next.key  = s_key;
                    item_next.data = s_entry_data;
                    div_next       = s_key;
                    rem_next       = '0;
                    n_next         = n_in;
                    step_next      = '0;
                    state_next     = dmrc_pkg::FRONT_DIVIDE;
                end
            end
            dmrc_pkg::FRONT_DIVIDE: begin
                rem_next  = dmrc_pkg::mod_step(rem_reg,
                                               div_reg[KEY_W-1 -: dmrc_pkg::MOD_BITS],
                                               n_reg);
                div_next  = div_reg << dmrc_pkg::MOD_BITS;
                step_next = step_reg + 1'b1;
                if (step_reg == dmrc_pkg::STEP_W'(dmrc_pkg::MOD_STEPS - 1)) begin
                    state_next = dmrc_pkg::FRONT_PUSH;
                end
            end
            dmrc_pkg::FRONT_PUSH: begin
                // Hold until the queue has room
                q_push = !q_full;
                if (!q_full) begin
                    state_next = dmrc_pkg::FRONT_IDLE;
                end
            end
            default: begin
                state_next = dmrc_pkg::FRONT_IDLE;
            end
        endcase
    end

    `DMRC_ASSERT_SAME(a_rem_below_divisor, state_reg != dmrc_pkg::FRONT_IDLE, (rem_reg < n_reg) && (n_reg != '0), "slot remainder not below slot count")

endmodule

`default_nettype wire

[hdl/dmrc_back.sv]
// Back half: clears the table, then reads, updates and answers one item at a time.
`default_nettype none

`include "direct_mapped_result_cache_unit_assert.svh"

module dmrc_back #(
    parameter int DEPTH        = 4096,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    output logic                              init_done,
    input  wire logic                         q_empty,
    output logic                              q_pop,
    input  wire dmrc_pkg::item_t              q_item,
    input  wire logic [$clog2(DEPTH)-1:0]     q_slot,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit,
    output logic [dmrc_pkg::DATA_W-1:0]       m_read_data,
    output logic [dmrc_pkg::CNT_W-1:0]        m_query_count,
    output logic [dmrc_pkg::CNT_W-1:0]        m_hit_count,
    output logic [dmrc_pkg::CNT_W-1:0]        m_entry_count,
    output logic [dmrc_pkg::CNT_W-1:0]        m_overwrite_count
);

    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int KEY_W   = dmrc_pkg::KEY_W;
    localparam int DATA_W  = dmrc_pkg::DATA_W;
    localparam int CNT_W   = dmrc_pkg::CNT_W;
    localparam int ENTRY_W = 1 + KEY_W + PAYLOAD_BITS;

    dmrc_pkg::back_state_t state_reg, state_next;
    dmrc_pkg::item_t       item_reg, item_next;
    logic [ADDR_W-1:0]  slot_reg, slot_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic               hit_reg, hit_next;
    logic [DATA_W-1:0]  rdata_reg, rdata_next;
    logic [CNT_W-1:0]   queries_reg, queries_next;
    logic [CNT_W-1:0]   hits_reg, hits_next;
    logic [CNT_W-1:0]   entries_reg, entries_next;
    logic [CNT_W-1:0]   overwrites_reg, overwrites_next;
    logic [CNT_W-1:0]   tally;
    logic               exec_go;

    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [ENTRY_W-1:0]      ram_wr_data;
    logic                    ram_rd_en;
    logic [ENTRY_W-1:0]      ram_rd_data;
    logic                    rd_valid;
    logic [KEY_W-1:0]        rd_key;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    // Each entry packs {valid, key, payload}
    dmrc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (q_slot),
        .rd_data (ram_rd_data)
    );

    assign rd_valid   = ram_rd_data[ENTRY_W-1];
    assign rd_key     = ram_rd_data[ENTRY_W-2 -: KEY_W];
    assign rd_payload = ram_rd_data[PAYLOAD_BITS-1:0];

    assign init_done         = (state_reg != dmrc_pkg::BACK_CLEAR);
    assign m_valid           = out_valid_reg;
    assign m_hit             = hit_reg;
    assign m_read_data       = rdata_reg;
    assign m_query_count     = queries_reg;
    assign m_hit_count       = hits_reg;
    assign m_entry_count     = entries_reg;
    assign m_overwrite_count = overwrites_reg;
    assign tally             = queries_reg + entries_reg + overwrites_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dmrc_pkg::BACK_CLEAR;
            clr_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
            queries_reg    <= '0;
            hits_reg       <= '0;
            entries_reg    <= '0;
            overwrites_reg <= '0;
        end else begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            queries_reg    <= queries_next;
            hits_reg       <= hits_next;
            entries_reg    <= entries_next;
            overwrites_reg <= overwrites_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
        rdata_reg <= rdata_next;
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        slot_next       = slot_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        hit_next        = hit_reg;
        rdata_next      = rdata_reg;
        queries_next    = queries_reg;
        hits_next       = hits_reg;
        entries_next    = entries_reg;
        overwrites_next = overwrites_reg;
        q_pop           = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = slot_reg;
        ram_wr_data     = {1'b1, item_reg.key, item_reg.data[PAYLOAD_BITS-1:0]};
        exec_go         = 1'b0;
        unique case (state_reg)
            dmrc_pkg::BACK_CLEAR: begin
                // Sweep the table and drop every valid bit
                ram_wr_en     = 1'b1;
                ram_wr_addr   = clr_addr_reg;
                ram_wr_data   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = dmrc_pkg::BACK_IDLE;
                end
            end
            dmrc_pkg::BACK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    ram_rd_en  = 1'b1;
                    item_next  = q_item;
                    slot_next  = q_slot;
                    state_next = dmrc_pkg::BACK_EXEC;
                end
            end
            dmrc_pkg::BACK_EXEC: begin
                // Wait for the output register to free up; read data holds meanwhile
                if (!out_valid_reg || m_ready) begin
                    exec_go        = 1'b1;
                    out_valid_next = 1'b1;
                    hit_next       = 1'b0;
                    rdata_next     = '0;
                    if (item_reg.cmd == dmrc_pkg::CMD_INSERT) begin
                        ram_wr_en = 1'b1;
                        if (rd_valid) begin
                            overwrites_next = overwrites_reg + 1'b1;
                        end else begin
                            entries_next = entries_reg + 1'b1;
                        end
                    end else begin
                        queries_next = queries_reg + 1'b1;
                        if (rd_valid && (rd_key == item_reg.key)) begin
                            hits_next  = hits_reg + 1'b1;
                            hit_next   = 1'b1;
                            rdata_next = DATA_W'(rd_payload);
                        end
                    end
                    state_next = dmrc_pkg::BACK_IDLE;
                end
            end
            default: begin
                state_next = dmrc_pkg::BACK_IDLE;
            end
        endcase
    end

    `DMRC_ASSERT_NEXT(a_counts_hold_while_stalled, m_valid && !m_ready, $stable(m_query_count) && $stable(m_hit_count) && $stable(m_entry_count) && $stable(m_overwrite_count), "counters moved while a result beat was stalled")
    `DMRC_ASSERT_NEXT(a_one_count_per_item, exec_go, tally == $past(tally) + 1'b1, "item did not advance exactly one of query, entry, overwrite")
    `DMRC_ASSERT_NEXT(a_insert_no_hit, exec_go && (item_reg.cmd == dmrc_pkg::CMD_INSERT), !m_hit && (m_read_data == '0), "insert result carries a hit or payload")

endmodule

`default_nettype wire

[hdl/direct_mapped_result_cache_unit.sv]
// Top level of the direct-mapped result cache: config register, front, queue and back.
`default_nettype none

// Direct-mapped cache of computed results. Each input beat is a lookup or an insert;
// the slot is key modulo table_size (zero counts as one, values above DEPTH clamp to
// DEPTH). Every item yields one result beat with the hit flag, the payload on a hit
// and the four wrapping counters after that item. After reset the slot table is
// swept clear, during which s_ready stays low. Each item then occupies the front
// from accept through 8 remainder steps of 4 bits in the modulo unit to hand-off
// to the queue, which waits while the queue is full; the front takes no new item
// until that hand-off. The back then reads the table, then updates and gives the
// result once the output register is free. Write table_size only while no item
// is in flight; table entries are not cleared by a size change.
module direct_mapped_result_cache_unit #(
    parameter int DEPTH        = 4096,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [dmrc_pkg::CFG_W-1:0]      cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_cmd,
    input  wire logic [dmrc_pkg::KEY_W-1:0]      s_key,
    input  wire logic [dmrc_pkg::DATA_W-1:0]     s_entry_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_hit,
    output logic      [dmrc_pkg::DATA_W-1:0]     m_read_data,
    output logic      [dmrc_pkg::CNT_W-1:0]      m_query_count,
    output logic      [dmrc_pkg::CNT_W-1:0]      m_hit_count,
    output logic      [dmrc_pkg::CNT_W-1:0]      m_entry_count,
    output logic      [dmrc_pkg::CNT_W-1:0]      m_overwrite_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int Q_W    = $bits(dmrc_pkg::item_t) + ADDR_W;

    logic [dmrc_pkg::CFG_W-1:0] table_size_reg;
    logic                       init_done;
    logic                       q_push;
    logic                       q_full;
    logic                       q_pop;
    logic                       q_empty;
    dmrc_pkg::item_t            push_item;
    logic [ADDR_W-1:0]          push_slot;
    dmrc_pkg::item_t            head_item;
    logic [ADDR_W-1:0]          head_slot;
    logic [Q_W-1:0]             head_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= dmrc_pkg::TABLE_SIZE_RESET;
        end else if (cfg_wr_en) begin
            table_size_reg <= cfg_wr_data;
        end
    end

    dmrc_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .init_done    (init_done),
        .table_size   (table_size_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_key        (s_key),
        .s_entry_data (s_entry_data),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item),
        .q_slot       (push_slot)
    );

    dmrc_queue #(
        .WIDTH (Q_W),
        .DEPTH (dmrc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_item, push_slot}),
        .full      (q_full),
        .pop       (q_pop),
        .head_data (head_data),
        .empty     (q_empty)
    );

    assign head_item = dmrc_pkg::item_t'(head_data[Q_W-1:ADDR_W]);
    assign head_slot = head_data[ADDR_W-1:0];

    dmrc_back #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .init_done         (init_done),
        .q_empty           (q_empty),
        .q_pop             (q_pop),
        .q_item            (head_item),
        .q_slot            (head_slot),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_read_data       (m_read_data),
        .m_query_count     (m_query_count),
        .m_hit_count       (m_hit_count),
        .m_entry_count     (m_entry_count),
        .m_overwrite_count (m_overwrite_count)
    );

endmodule

`default_nettype wire

[tb/dmrc_access_checker.sv]
`timescale 1ns / 100ps
// Checker that mirrors the result cache table and compares every result beat.
module dmrc_access_checker #(
    parameter int DEPTH        = 4096,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dmrc_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [dmrc_pkg::KEY_W-1:0]    s_key,
    input  logic [dmrc_pkg::DATA_W-1:0]   s_entry_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_hit,
    input  logic [dmrc_pkg::DATA_W-1:0]   m_read_data,
    input  logic [dmrc_pkg::CNT_W-1:0]    m_query_count,
    input  logic [dmrc_pkg::CNT_W-1:0]    m_hit_count,
    input  logic [dmrc_pkg::CNT_W-1:0]    m_entry_count,
    input  logic [dmrc_pkg::CNT_W-1:0]    m_overwrite_count,
    output int unsigned                   mismatch_count,
    output int unsigned                   results_pending
);

    localparam int KEY_W  = dmrc_pkg::KEY_W;
    localparam int DATA_W = dmrc_pkg::DATA_W;
    localparam int CNT_W  = dmrc_pkg::CNT_W;
    localparam int CFG_W  = dmrc_pkg::CFG_W;

    localparam logic [DATA_W-1:0] PAYLOAD_MASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  queries;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  entries;
        logic [CNT_W-1:0]  overwrites;
    } access_result_t;

    logic              mirror_valid   [DEPTH];
    logic [KEY_W-1:0]  mirror_key     [DEPTH];
    logic [DATA_W-1:0] mirror_payload [DEPTH];
    logic [CNT_W-1:0]  n_queries, n_hits, n_entries, n_overwrites;
    logic [CFG_W-1:0]  table_size;

    access_result_t    access_results_q [$];
    int unsigned       fail_total = 0;
    int unsigned       pending    = 0;

    assign mismatch_count  = fail_total;
    assign results_pending = pending;

    // Apply one access to the mirrored table and return the result it must produce.
    function automatic access_result_t predict_access(
        input dmrc_pkg::cmd_t    cmd,
        input logic [KEY_W-1:0]  key,
        input logic [DATA_W-1:0] data
    );
        access_result_t res;
        int unsigned    slots;
        int unsigned    slot;
        slots = table_size;
        if (slots == 0) begin
            slots = 1;
        end
        if (slots > DEPTH) begin
            slots = DEPTH;
        end
        slot = key % slots;
        res  = '0;
        if (cmd == dmrc_pkg::CMD_INSERT) begin
            if (mirror_valid[slot]) begin
                n_overwrites = n_overwrites + 1'b1;
            end else begin
                n_entries = n_entries + 1'b1;
            end
            mirror_valid[slot]   = 1'b1;
            mirror_key[slot]     = key;
            mirror_payload[slot] = data & PAYLOAD_MASK;
        end else begin
            n_queries = n_queries + 1'b1;
            if (mirror_valid[slot] && mirror_key[slot] == key) begin
                n_hits        = n_hits + 1'b1;
                res.hit       = 1'b1;
                res.read_data = mirror_payload[slot];
            end
        end
        res.queries    = n_queries;
        res.hits       = n_hits;
        res.entries    = n_entries;
        res.overwrites = n_overwrites;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] result beat error: %s", $time, what);
        fail_total++;
    endtask

    task automatic check_field(
        input string             field,
        input logic [DATA_W-1:0] got,
        input logic [DATA_W-1:0] want
    );
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", field, got, want));
        end
    endtask

    always @(posedge aclk) begin
        access_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                mirror_valid[i] = 1'b0;
            end
            n_queries    = '0;
            n_hits       = '0;
            n_entries    = '0;
            n_overwrites = '0;
            table_size   = dmrc_pkg::TABLE_SIZE_RESET;
            access_results_q.delete();
        end else begin
            if (cfg_wr_en) begin
                table_size = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                access_results_q.push_back(
                    predict_access(dmrc_pkg::cmd_t'(s_cmd), s_key, s_entry_data));
            end
            if (m_valid && m_ready) begin
                if (access_results_q.size() == 0) begin
                    report_mismatch("beat arrived with no access outstanding");
                end else begin
                    want = access_results_q.pop_front();
                    check_field("hit", m_hit, want.hit);
                    check_field("read_data", m_read_data, want.read_data);
                    check_field("query_count", m_query_count, want.queries);
                    check_field("hit_count", m_hit_count, want.hits);
                    check_field("entry_count", m_entry_count, want.entries);
                    check_field("overwrite_count", m_overwrite_count, want.overwrites);
                end
            end
        end
        pending <= access_results_q.size();
    end

endmodule

[tb/tb_direct_mapped_result_cache_unit.sv]
`timescale 1ns / 100ps
// Top of the result cache testbench: clock, reset, access stimulus and verdict.
module tb_direct_mapped_result_cache_unit;

    localparam int DEPTH          = 4096;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int ITEMS_PER_SIZE = 100;
    localparam int POOL_DEPTH     = 48;
    localparam int QUIET_PHASE    = 3;
    localparam int KEY_W          = dmrc_pkg::KEY_W;
    localparam int DATA_W         = dmrc_pkg::DATA_W;
    localparam int CNT_W          = dmrc_pkg::CNT_W;
    localparam int CFG_W          = dmrc_pkg::CFG_W;

    logic              aclk;
    logic              aresetn      = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data  = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic              s_cmd        = dmrc_pkg::CMD_LOOKUP;
    logic [KEY_W-1:0]  s_key        = '0;
    logic [DATA_W-1:0] s_entry_data = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic              m_hit;
    logic [DATA_W-1:0] m_read_data;
    logic [CNT_W-1:0]  m_query_count;
    logic [CNT_W-1:0]  m_hit_count;
    logic [CNT_W-1:0]  m_entry_count;
    logic [CNT_W-1:0]  m_overwrite_count;

    int unsigned       mismatch_count;
    int unsigned       results_pending;
    int unsigned       cycle_count = 0;
    bit                no_idling   = 1'b0;
    int unsigned       slots_now   = DEPTH;
    logic [KEY_W-1:0]  key_pool [$];
    logic [CFG_W-1:0]  phase_sizes [10] = '{13'd1, 13'd0, 13'd8191, 13'd4097, 13'd7,
                                            13'd64, 13'd4095, 13'd4096, 13'd3000, 13'd2};

    direct_mapped_result_cache_unit #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (64)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_key             (s_key),
        .s_entry_data      (s_entry_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_read_data       (m_read_data),
        .m_query_count     (m_query_count),
        .m_hit_count       (m_hit_count),
        .m_entry_count     (m_entry_count),
        .m_overwrite_count (m_overwrite_count)
    );

    dmrc_access_checker #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (64)
    ) access_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_key             (s_key),
        .s_entry_data      (s_entry_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_hit             (m_hit),
        .m_read_data       (m_read_data),
        .m_query_count     (m_query_count),
        .m_hit_count       (m_hit_count),
        .m_entry_count     (m_entry_count),
        .m_overwrite_count (m_overwrite_count),
        .mismatch_count    (mismatch_count),
        .results_pending   (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= no_idling || ($urandom_range(0, 99) >= 36);
    end

    task automatic write_table_size(input logic [CFG_W-1:0] size);
        int unsigned n;
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n = size;
        if (n == 0) begin
            n = 1;
        end
        if (n > DEPTH) begin
            n = DEPTH;
        end
        slots_now = n;
    endtask

    task automatic send_access(
        input dmrc_pkg::cmd_t    cmd,
        input logic [KEY_W-1:0]  key,
        input logic [DATA_W-1:0] data
    );
        if (!no_idling && $urandom_range(0, 99) < 36) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < 36);
        end
        s_valid      <= 1'b1;
        s_cmd        <= cmd;
        s_key        <= key;
        s_entry_data <= data;
        // hold the beat until it is taken
        do @(posedge aclk); while (!s_ready);
        if (cmd == dmrc_pkg::CMD_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) begin
                key_pool.delete(0);
            end
        end
    endtask

    // Mostly reuse recent keys so that lookups hit and inserts overwrite.
    task automatic send_random_access();
        dmrc_pkg::cmd_t   cmd;
        logic [KEY_W-1:0] key;
        int unsigned      pick;
        if ($urandom_range(0, 99) < 50) begin
            cmd = dmrc_pkg::CMD_LOOKUP;
        end else begin
            cmd = dmrc_pkg::CMD_INSERT;
        end
        pick = $urandom_range(0, 99);
        if (key_pool.size() == 0 || pick < 25) begin
            key = $urandom;
        end else begin
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if (pick >= 75) begin
                // same slot, different key
                key = key + slots_now * $urandom_range(1, 3);
            end
        end
        send_access(cmd, key, {$urandom, $urandom});
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        write_table_size(dmrc_pkg::TABLE_SIZE_RESET);

        send_access(dmrc_pkg::CMD_LOOKUP, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(dmrc_pkg::CMD_INSERT, 32'h0000_0000, 64'h0000_0000_0000_0000);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'h0000_0000, 64'h0000_0000_0000_0000);
        send_access(dmrc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 64'h0000_0000_0000_0000);
        send_access(dmrc_pkg::CMD_INSERT, 32'h0000_1000, 64'h0123_4567_89AB_CDEF);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'h0000_0000, 64'h0000_0000_0000_0000);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'h0000_1000, 64'h0000_0000_0000_0000);
        send_access(dmrc_pkg::CMD_INSERT, 32'h0000_1000, 64'hFEDC_BA98_7654_3210);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'h0000_1000, 64'hDEAD_BEEF_DEAD_BEEF);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'h8000_0FFF, 64'h0000_0000_0000_0000);
        send_access(dmrc_pkg::CMD_INSERT, 32'hAAAA_5555, 64'h5555_AAAA_5555_AAAA);
        send_access(dmrc_pkg::CMD_LOOKUP, 32'hAAAA_5555, 64'h0000_0000_0000_0000);
        wait_results_drained();

        // the table is kept across size changes, so old keys stay in the pool
        foreach (phase_sizes[p]) begin
            write_table_size(phase_sizes[p]);
            no_idling <= (p == QUIET_PHASE);
            repeat (ITEMS_PER_SIZE) send_random_access();
            wait_results_drained();
        end

        repeat (30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[direct_mapped_result_cache_unit.f]
+incdir+hdl
hdl/dmrc_pkg.sv
hdl/dmrc_ram.sv
hdl/dmrc_queue.sv
hdl/dmrc_front.sv
hdl/dmrc_back.sv
hdl/direct_mapped_result_cache_unit.sv
tb/dmrc_access_checker.sv
tb/tb_direct_mapped_result_cache_unit.sv
